// File: hdl/gbt_pkg.sv
`default_nettype none

package gbt_pkg;

    localparam int VERT_W = 6;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 7;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_DEGREE   = 8;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic [REQ_W-1:0] REQ_EDGE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BFS  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DFS  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [VERT_W-1:0] vertex;
        logic              last;
        logic [STAT_W-1:0] status;
    } result_t;

endpackage

`default_nettype wire

// File: hdl/gbt_ram.sv
`default_nettype none

module gbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hdl/gbt_out_reg.sv
`default_nettype none

module gbt_out_reg (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       ld_valid,
    input  wire gbt_pkg::result_t           ld_data,
    output logic                            free,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [gbt_pkg::VERT_W-1:0]      m_visited_vertex,
    output logic                            m_last_of_run,
    output logic [gbt_pkg::STAT_W-1:0]      m_status
);

    logic             vld_reg;
    gbt_pkg::result_t data_reg;

    // The slot is free when empty or when its beat leaves in this cycle.
    assign free = !vld_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (free) begin
            vld_reg <= ld_valid;
        end
        if (free && ld_valid) begin
            data_reg <= ld_data;
        end
    end

    assign m_valid          = vld_reg;
    assign m_visited_vertex = data_reg.vertex;
    assign m_last_of_run    = data_reg.last;
    assign m_status         = data_reg.status;

endmodule

`default_nettype wire

// File: hdl/graph_bfs_dfs_traversal.sv
`default_nettype none

// Channel  | Direction | Handshake          | Payload
// s_       | in        | s_valid / s_ready  | s_req_type, s_vertex_a, s_vertex_b
// m_       | out       | m_valid / m_ready  | m_visited_vertex, m_last_of_run, m_status
// cfg_     | in        | cfg_wr_en          | cfg_wr_data (vertex_count)
//
// One request is worked on at a time; s_ready is high only while the sequencer is idle.
// BFS and DFS walks read each adjacency entry through the one read port of the adjacency memory.
// Reset clears the degree valid bits, so no clearing pass runs; output stalls hold the walk.

module graph_bfs_dfs_traversal #(
    parameter int MAX_VERTICES = gbt_pkg::DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = gbt_pkg::DEF_MAX_DEGREE
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [gbt_pkg::CFG_W-1:0]   cfg_wr_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [gbt_pkg::REQ_W-1:0]   s_req_type,
    input  wire logic [gbt_pkg::VERT_W-1:0]  s_vertex_a,
    input  wire logic [gbt_pkg::VERT_W-1:0]  s_vertex_b,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [gbt_pkg::VERT_W-1:0]       m_visited_vertex,
    output logic                             m_last_of_run,
    output logic [gbt_pkg::STAT_W-1:0]       m_status
);

    localparam int VIDX_W  = $clog2(MAX_VERTICES);
    localparam int DEG_W   = $clog2(MAX_DEGREE + 1);
    localparam int NADDR_W = $clog2(MAX_VERTICES * MAX_DEGREE);
    localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
    localparam int WALK_W  = VIDX_W + DEG_W;
    localparam int NW      = (CNT_W > gbt_pkg::CFG_W) ? CNT_W : gbt_pkg::CFG_W;
    localparam int VW      = gbt_pkg::VERT_W;

    localparam logic [NW-1:0]      MAXV_N = NW'(MAX_VERTICES);
    localparam logic [DEG_W-1:0]   MAXD_D = DEG_W'(MAX_DEGREE);
    localparam logic [DEG_W:0]     MAXD_X = (DEG_W+1)'(MAX_DEGREE);
    localparam logic [NADDR_W-1:0] MAXD_A = NADDR_W'(MAX_DEGREE);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_RESP   = 5'd1;
    localparam logic [4:0] S_E_A    = 5'd2;
    localparam logic [4:0] S_E_B    = 5'd3;
    localparam logic [4:0] S_E_CHK  = 5'd4;
    localparam logic [4:0] S_E_W2   = 5'd5;
    localparam logic [4:0] S_B_POP  = 5'd6;
    localparam logic [4:0] S_B_CUR  = 5'd7;
    localparam logic [4:0] S_B_EMIT = 5'd8;
    localparam logic [4:0] S_B_DEG  = 5'd9;
    localparam logic [4:0] S_B_NB   = 5'd10;
    localparam logic [4:0] S_D_DEG  = 5'd11;
    localparam logic [4:0] S_D_STEP = 5'd12;
    localparam logic [4:0] S_D_NBD  = 5'd13;
    localparam logic [4:0] S_D_PUSH = 5'd14;
    localparam logic [4:0] S_D_POPD = 5'd15;
    localparam logic [4:0] S_FIN    = 5'd16;

    logic [4:0]                  state_reg, state_next;
    logic [gbt_pkg::CFG_W-1:0]   vcount_reg;
    logic [VW-1:0]               va_reg, va_next, vb_reg, vb_next;
    logic [DEG_W-1:0]            da_reg, da_next, db_reg, db_next;
    logic [gbt_pkg::STAT_W-1:0]  stat_reg, stat_next;
    logic                        pend_vld_reg, pend_vld_next;
    logic [VW-1:0]               pend_vtx_reg, pend_vtx_next;
    logic [VIDX_W-1:0]           cur_reg, cur_next;
    logic [DEG_W-1:0]            slot_reg, slot_next, deg_reg, deg_next;
    logic [CNT_W-1:0]            head_reg, head_next, tail_reg, tail_next;
    logic [CNT_W-1:0]            depth_reg, depth_next;
    logic                        nbq_reg, nbq_next, nbok_reg, nbok_next;
    logic [VW-1:0]               nb_reg, nb_next;
    logic [MAX_VERTICES-1:0]     visited_reg, visited_next;
    logic [MAX_VERTICES-1:0]     deg_vld_reg, deg_vld_next;
    logic                        deg_vq_reg;

    logic [NW-1:0]               n_eff;
    logic                        out_free, out_ld;
    gbt_pkg::result_t            out_data;
    logic                        accept, can_emit;
    logic [CNT_W-1:0]            dm1, dm2;

    logic                        nbr_we;
    logic [NADDR_W-1:0]          nbr_waddr, nbr_raddr;
    logic [VW-1:0]               nbr_wdata, nbr_rdata;
    logic                        deg_we;
    logic [VIDX_W-1:0]           deg_waddr, deg_raddr;
    logic [DEG_W-1:0]            deg_wdata, deg_rdata, deg_eff;
    logic                        walk_we;
    logic [VIDX_W-1:0]           walk_waddr, walk_raddr;
    logic [WALK_W-1:0]           walk_wdata, walk_rdata;
    logic [DEG_W-1:0]            db_eff;
    logic                        nb_ok;

    gbt_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES * MAX_DEGREE)) u_nbr_ram (
        .aclk(aclk), .wr_en(nbr_we), .wr_addr(nbr_waddr), .wr_data(nbr_wdata),
        .rd_addr(nbr_raddr), .rd_data(nbr_rdata)
    );

    gbt_ram #(.WIDTH(DEG_W), .DEPTH(MAX_VERTICES)) u_deg_ram (
        .aclk(aclk), .wr_en(deg_we), .wr_addr(deg_waddr), .wr_data(deg_wdata),
        .rd_addr(deg_raddr), .rd_data(deg_rdata)
    );

    gbt_ram #(.WIDTH(WALK_W), .DEPTH(MAX_VERTICES)) u_walk_ram (
        .aclk(aclk), .wr_en(walk_we), .wr_addr(walk_waddr), .wr_data(walk_wdata),
        .rd_addr(walk_raddr), .rd_data(walk_rdata)
    );

    gbt_out_reg u_out (
        .aclk(aclk), .aresetn(aresetn), .ld_valid(out_ld), .ld_data(out_data),
        .free(out_free), .m_valid(m_valid), .m_ready(m_ready),
        .m_visited_vertex(m_visited_vertex), .m_last_of_run(m_last_of_run),
        .m_status(m_status)
    );

    assign n_eff    = (NW'(vcount_reg) > MAXV_N) ? MAXV_N : NW'(vcount_reg);
    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    // A new vertex may enter the pending slot once the previous one can move on.
    assign can_emit = !pend_vld_reg || out_free;
    assign deg_eff  = deg_vq_reg ? deg_rdata : '0;
    assign dm1      = depth_reg - CNT_W'(1);
    assign dm2      = depth_reg - CNT_W'(2);
    assign db_eff   = (va_reg == vb_reg) ? (da_reg + DEG_W'(1)) : db_reg;
    assign nb_ok    = (NW'(nbr_rdata) < n_eff) && !visited_reg[VIDX_W'(nbr_rdata)];

    always_comb begin
        state_next    = state_reg;
        va_next       = va_reg;
        vb_next       = vb_reg;
        da_next       = da_reg;
        db_next       = db_reg;
        stat_next     = stat_reg;
        pend_vld_next = pend_vld_reg;
        pend_vtx_next = pend_vtx_reg;
        cur_next      = cur_reg;
        slot_next     = slot_reg;
        deg_next      = deg_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        depth_next    = depth_reg;
        nbq_next      = nbq_reg;
        nbok_next     = nbok_reg;
        nb_next       = nb_reg;
        visited_next  = visited_reg;
        deg_vld_next  = deg_vld_reg;
        out_ld        = 1'b0;
        out_data      = '{vertex: pend_vtx_reg, last: 1'b0, status: gbt_pkg::STAT_OK};
        nbr_we        = 1'b0;
        nbr_waddr     = '0;
        nbr_wdata     = '0;
        nbr_raddr     = '0;
        deg_we        = 1'b0;
        deg_waddr     = '0;
        deg_wdata     = '0;
        deg_raddr     = '0;
        walk_we       = 1'b0;
        walk_waddr    = '0;
        walk_wdata    = '0;
        walk_raddr    = '0;

        unique case (state_reg)
            S_IDLE: begin
                va_next = s_vertex_a;
                vb_next = s_vertex_b;
                deg_raddr = VIDX_W'(s_vertex_a);
                if (accept) begin
                    if (s_req_type == gbt_pkg::REQ_EDGE) begin
                        if (NW'(s_vertex_a) >= n_eff || NW'(s_vertex_b) >= n_eff) begin
                            stat_next  = gbt_pkg::STAT_RANGE;
                            state_next = S_RESP;
                        end else begin
                            state_next = S_E_A;
                        end
                    end else if (s_req_type == gbt_pkg::REQ_BFS ||
                                 s_req_type == gbt_pkg::REQ_DFS) begin
                        if (NW'(s_vertex_a) >= n_eff) begin
                            stat_next  = gbt_pkg::STAT_RANGE;
                            state_next = S_RESP;
                        end else begin
                            visited_next = '0;
                            visited_next[VIDX_W'(s_vertex_a)] = 1'b1;
                            cur_next  = VIDX_W'(s_vertex_a);
                            slot_next = '0;
                            if (s_req_type == gbt_pkg::REQ_BFS) begin
                                walk_we    = 1'b1;
                                walk_waddr = '0;
                                walk_wdata = {VIDX_W'(s_vertex_a), DEG_W'(0)};
                                head_next  = '0;
                                tail_next  = CNT_W'(1);
                                state_next = S_B_POP;
                            end else begin
                                pend_vld_next = 1'b1;
                                pend_vtx_next = s_vertex_a;
                                depth_next    = CNT_W'(1);
                                state_next    = S_D_DEG;
                            end
                        end
                    end
                end
            end

            S_RESP: begin
                if (out_free) begin
                    out_ld     = 1'b1;
                    out_data   = '{vertex: '0, last: 1'b1, status: stat_reg};
                    state_next = S_IDLE;
                end
            end

            S_E_A: begin
                da_next    = deg_eff;
                deg_raddr  = VIDX_W'(vb_reg);
                state_next = S_E_B;
            end

            S_E_B: begin
                db_next    = deg_eff;
                state_next = S_E_CHK;
            end

            S_E_CHK: begin
                // A self-loop needs two free slots in the one list.
                if ((va_reg == vb_reg) ? ({1'b0, da_reg} + (DEG_W+1)'(2) > MAXD_X)
                                       : (da_reg >= MAXD_D || db_reg >= MAXD_D)) begin
                    stat_next  = gbt_pkg::STAT_FULL;
                    state_next = S_RESP;
                end else begin
                    nbr_we    = 1'b1;
                    nbr_waddr = NADDR_W'(VIDX_W'(va_reg)) * MAXD_A + NADDR_W'(da_reg);
                    nbr_wdata = vb_reg;
                    deg_we    = 1'b1;
                    deg_waddr = VIDX_W'(va_reg);
                    deg_wdata = da_reg + DEG_W'(1);
                    deg_vld_next[VIDX_W'(va_reg)] = 1'b1;
                    state_next = S_E_W2;
                end
            end

            S_E_W2: begin
                nbr_we    = 1'b1;
                nbr_waddr = NADDR_W'(VIDX_W'(vb_reg)) * MAXD_A + NADDR_W'(db_eff);
                nbr_wdata = va_reg;
                deg_we    = 1'b1;
                deg_waddr = VIDX_W'(vb_reg);
                deg_wdata = db_eff + DEG_W'(1);
                deg_vld_next[VIDX_W'(vb_reg)] = 1'b1;
                stat_next  = gbt_pkg::STAT_OK;
                state_next = S_RESP;
            end

            S_B_POP: begin
                walk_raddr = head_reg[VIDX_W-1:0];
                if (head_reg == tail_reg) begin
                    state_next = S_FIN;
                end else begin
                    head_next  = head_reg + CNT_W'(1);
                    state_next = S_B_CUR;
                end
            end

            S_B_CUR: begin
                cur_next   = walk_rdata[WALK_W-1:DEG_W];
                state_next = S_B_EMIT;
            end

            S_B_EMIT: begin
                deg_raddr = cur_reg;
                if (can_emit) begin
                    out_ld        = pend_vld_reg;
                    pend_vld_next = 1'b1;
                    pend_vtx_next = VW'(cur_reg);
                    state_next    = S_B_DEG;
                end
            end

            S_B_DEG: begin
                deg_next   = deg_eff;
                slot_next  = '0;
                nbq_next   = 1'b0;
                state_next = S_B_NB;
            end

            S_B_NB: begin
                // Reads are issued back to back; each entry is checked in the cycle after its read.
                if (nbq_reg && nb_ok) begin
                    visited_next[VIDX_W'(nbr_rdata)] = 1'b1;
                    walk_we    = 1'b1;
                    walk_waddr = tail_reg[VIDX_W-1:0];
                    walk_wdata = {VIDX_W'(nbr_rdata), DEG_W'(0)};
                    tail_next  = tail_reg + CNT_W'(1);
                end
                nbr_raddr = NADDR_W'(cur_reg) * MAXD_A + NADDR_W'(slot_reg);
                if (slot_reg < deg_reg) begin
                    slot_next = slot_reg + DEG_W'(1);
                    nbq_next  = 1'b1;
                end else begin
                    nbq_next = 1'b0;
                    if (!nbq_reg) begin
                        state_next = S_B_POP;
                    end
                end
            end

            S_D_DEG: begin
                deg_next   = deg_eff;
                state_next = S_D_STEP;
            end

            S_D_STEP: begin
                nbr_raddr  = NADDR_W'(cur_reg) * MAXD_A + NADDR_W'(slot_reg);
                walk_raddr = dm2[VIDX_W-1:0];
                if (slot_reg >= deg_reg) begin
                    depth_next = dm1;
                    state_next = (depth_reg == CNT_W'(1)) ? S_FIN : S_D_POPD;
                end else begin
                    slot_next  = slot_reg + DEG_W'(1);
                    state_next = S_D_NBD;
                end
            end

            S_D_NBD: begin
                nb_next    = nbr_rdata;
                nbok_next  = nb_ok;
                state_next = S_D_PUSH;
            end

            S_D_PUSH: begin
                deg_raddr = VIDX_W'(nb_reg);
                if (!nbok_reg) begin
                    state_next = S_D_STEP;
                end else if (can_emit) begin
                    out_ld        = pend_vld_reg;
                    pend_vld_next = 1'b1;
                    pend_vtx_next = nb_reg;
                    visited_next[VIDX_W'(nb_reg)] = 1'b1;
                    walk_we    = 1'b1;
                    walk_waddr = dm1[VIDX_W-1:0];
                    walk_wdata = {cur_reg, slot_reg};
                    cur_next   = VIDX_W'(nb_reg);
                    slot_next  = '0;
                    depth_next = depth_reg + CNT_W'(1);
                    state_next = S_D_DEG;
                end
            end

            S_D_POPD: begin
                cur_next   = walk_rdata[WALK_W-1:DEG_W];
                slot_next  = walk_rdata[DEG_W-1:0];
                deg_raddr  = walk_rdata[WALK_W-1:DEG_W];
                state_next = S_D_DEG;
            end

            S_FIN: begin
                if (out_free) begin
                    out_ld        = 1'b1;
                    out_data.last = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            vcount_reg   <= gbt_pkg::CFG_RESET;
            pend_vld_reg <= 1'b0;
            deg_vld_reg  <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            depth_reg    <= '0;
            nbq_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pend_vld_reg <= pend_vld_next;
            deg_vld_reg  <= deg_vld_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            depth_reg    <= depth_next;
            nbq_reg      <= nbq_next;
            if (cfg_wr_en) begin
                vcount_reg <= cfg_wr_data;
            end
        end
        va_reg       <= va_next;
        vb_reg       <= vb_next;
        da_reg       <= da_next;
        db_reg       <= db_next;
        stat_reg     <= stat_next;
        pend_vtx_reg <= pend_vtx_next;
        cur_reg      <= cur_next;
        slot_reg     <= slot_next;
        deg_reg      <= deg_next;
        nbok_reg     <= nbok_next;
        nb_reg       <= nb_next;
        visited_reg  <= visited_next;
        deg_vq_reg   <= deg_vld_reg[deg_raddr];
    end

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pend_vld_reg)
        else $error("pending vertex left over while idle");

    a_queue_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg <= tail_reg) && (tail_reg <= CNT_W'(MAX_VERTICES)))
        else $error("BFS queue pointers out of order");

    a_stack_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= CNT_W'(MAX_VERTICES))
        else $error("DFS stack deeper than vertex count");

    a_fin_has_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN) |-> pend_vld_reg)
        else $error("walk finished without a vertex to mark last");

endmodule

`default_nettype wire
